// File: src/rcw_pkg.sv
// Package for the rolling checksum window unit: sizes, codes, payload types and helpers.
package rcw_pkg;

   // Window store depth and derived widths
   localparam int WINDOW_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int CFG_LEN_W    = 13;
   localparam int CMP_W        = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
   localparam int PROD_W       = LEN_W + 9;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_OFFSET   = CSR_IDX_W'(1);

   localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RESET = CFG_LEN_W'(2048);
   localparam logic [7:0]           CHAR_OFFSET_RESET   = 8'd31;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [31:0] sum_low;
      logic [31:0] sum_high;
      logic        window_full;
      logic        evicted_valid;
      logic [7:0]  evicted_byte;
   } rsp_type;

   // Active configuration, held by the control block
   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [7:0]       offset;
   } cfg_type;

   // Item state passed from the access stage to the sum stage
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
      logic       rotate;
      logic       full;
   } meta_type;

   // Window length as used: zero means one, large values saturate to the depth
   function automatic logic [LEN_W-1:0] eff_length(input logic [CFG_LEN_W-1:0] value);
      logic [CMP_W-1:0] ext;
      logic [LEN_W-1:0] res;
      ext = CMP_W'(value);
      if (ext == '0) begin
         res = LEN_W'(1);
      end else if (ext > CMP_W'(WINDOW_DEPTH)) begin
         res = LEN_W'(WINDOW_DEPTH);
      end else begin
         res = LEN_W'(ext);
      end
      return res;
   endfunction

endpackage

// File: src/rcw_window_ram.sv
// Window byte store: one read-first port, write and registered read at the same address.
module rcw_window_ram (
   input  logic                     clock,
   input  logic                     access,
   input  logic [rcw_pkg::ADDR_W-1:0] addr,
   input  logic [7:0]               wr_data,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [rcw_pkg::WINDOW_DEPTH];
   logic [7:0] rd_data_ff;

   // Read returns the byte held before this cycle's write
   always_ff @(posedge clock) begin
      if (access) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rcw_ctrl.sv
// Access stage: configuration registers, fill count, oldest pointer and store addressing.
module rcw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  rcw_pkg::req_type              req_data,
   input  logic                          csr_write,
   input  logic [rcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcw_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [rcw_pkg::ADDR_W-1:0]     ram_addr,
   output rcw_pkg::meta_type              meta,
   output rcw_pkg::cfg_type               cfg,
   output logic                          clear_sums
);

   rcw_pkg::cfg_type            cfg_ff, cfg_in;
   logic [rcw_pkg::ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [rcw_pkg::LEN_W-1:0]   fill_ff, fill_in;
   logic                        full_ff, full_in;

   logic                        full_c;
   logic [rcw_pkg::LEN_W-1:0]   fill_c;
   logic [rcw_pkg::ADDR_W-1:0]  ptr_c;
   logic [rcw_pkg::ADDR_W-1:0]  idx;
   logic [rcw_pkg::LEN_W-1:0]   idx_next;
   logic                        len_write;

   // Configuration decode
   always_comb begin
      cfg_in    = cfg_ff;
      len_write = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            rcw_pkg::CSR_WINDOW_LENGTH: begin
               cfg_in.length = rcw_pkg::eff_length(csr_wdata[rcw_pkg::CFG_LEN_W-1:0]);
               len_write     = 1'b1;
            end
            rcw_pkg::CSR_CHAR_OFFSET: begin
               cfg_in.offset = csr_wdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Window position for this item, after an optional restart
   always_comb begin
      full_c   = req_data.restart ? 1'b0 : full_ff;
      fill_c   = req_data.restart ? '0 : fill_ff;
      ptr_c    = req_data.restart ? '0 : ptr_ff;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      full_in  = full_ff;
      idx      = '0;
      idx_next = '0;
      if (!full_c) begin
         if (fill_c < cfg_ff.length) begin
            idx = fill_c[rcw_pkg::ADDR_W-1:0];
         end
         idx_next = rcw_pkg::LEN_W'(idx) + rcw_pkg::LEN_W'(1);
         if (accept) begin
            fill_in = idx_next;
            full_in = (idx_next >= cfg_ff.length);
            ptr_in  = ptr_c;
         end
      end else begin
         if (rcw_pkg::LEN_W'(ptr_c) < cfg_ff.length) begin
            idx = ptr_c;
         end
         idx_next = rcw_pkg::LEN_W'(idx) + rcw_pkg::LEN_W'(1);
         if (accept) begin
            ptr_in  = (idx_next >= cfg_ff.length) ? '0 : idx_next[rcw_pkg::ADDR_W-1:0];
            fill_in = fill_c;
            full_in = 1'b1;
         end
      end
      if (len_write) begin
         ptr_in  = '0;
         fill_in = '0;
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length <= rcw_pkg::eff_length(rcw_pkg::WINDOW_LENGTH_RESET);
         cfg_ff.offset <= rcw_pkg::CHAR_OFFSET_RESET;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         full_ff       <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
         full_ff <= full_in;
      end
   end

   assign ram_addr       = idx;
   assign meta.data_byte = req_data.data_byte;
   assign meta.restart   = req_data.restart;
   assign meta.rotate    = full_c;
   assign meta.full      = full_in;
   assign cfg            = cfg_ff;
   assign clear_sums     = len_write;

endmodule

// File: src/rcw_sum.sv
// Sum stage: updates s1 and s2 from the store read data and holds the result register.
module rcw_sum (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rcw_pkg::meta_type meta,
   input  rcw_pkg::cfg_type  cfg,
   input  logic              clear_sums,
   input  logic [7:0]        old_byte,
   input  logic              rsp_stall,
   output logic              busy,
   output logic              rsp_valid,
   output rcw_pkg::rsp_type  rsp_data
);

   logic              stage_valid_ff, stage_valid_in;
   rcw_pkg::meta_type stage_meta_ff;
   logic [31:0]       s1_ff, s1_in;
   logic [31:0]       s2_ff, s2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rcw_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic                        advance;
   logic [31:0]                 s1_base;
   logic [31:0]                 s2_base;
   logic [31:0]                 s1_next;
   logic [31:0]                 s2_next;
   logic [rcw_pkg::PROD_W-1:0]  drop;

   assign advance = stage_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign busy    = stage_valid_ff && !advance;

   // Rolling update: fill adds byte plus offset, rotate swaps old for new
   always_comb begin
      s1_base = stage_meta_ff.restart ? 32'd0 : s1_ff;
      s2_base = stage_meta_ff.restart ? 32'd0 : s2_ff;
      drop    = rcw_pkg::PROD_W'(cfg.length) *
                rcw_pkg::PROD_W'({1'b0, old_byte} + {1'b0, cfg.offset});
      if (stage_meta_ff.rotate) begin
         s1_next = s1_base + 32'(stage_meta_ff.data_byte) - 32'(old_byte);
         s2_next = s2_base + s1_next - 32'(drop);
      end else begin
         s1_next = s1_base + 32'(stage_meta_ff.data_byte) + 32'(cfg.offset);
         s2_next = s2_base + s1_next;
      end
   end

   // Stage, sum and result register updates
   always_comb begin
      stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      s1_in          = s1_ff;
      s2_in          = s2_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      if (advance) begin
         s1_in                     = s1_next;
         s2_in                     = s2_next;
         rsp_valid_in              = 1'b1;
         rsp_data_in.sum_low       = s1_next;
         rsp_data_in.sum_high      = s2_next;
         rsp_data_in.window_full   = stage_meta_ff.full;
         rsp_data_in.evicted_valid = stage_meta_ff.rotate;
         rsp_data_in.evicted_byte  = stage_meta_ff.rotate ? old_byte : 8'd0;
      end
      if (clear_sums) begin
         s1_in = '0;
         s2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         s1_ff          <= '0;
         s2_ff          <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         s1_ff          <= s1_in;
         s2_ff          <= s2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_meta_ff <= meta;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/rolling_checksum_window_unit.sv
// Top level of the rolling checksum window unit.
//
// Takes one byte per item on the req_ channel and returns one result per item on
// the rsp_ channel: running s1 and s2 sums, the window full flag and the byte
// pushed out of the window once it is full. A restart bit in the item clears the
// window and sums before that byte is taken.
// Each item passes through the sum stage register, which also receives the store read
// data, and then the result register, which holds while the receiver stalls.
// Throughput: one item per cycle while the receiver does not stall; the store is read
// and written once per item at the same address, and the sum stage adds one s1/s2 update per cycle.
// The receiver may stall: the result register holds, one more item waits in the
// sum stage, and req_stall rises only while both are occupied.
// Configuration goes through the csr_ port, which is always ready; write it only
// while no item is in flight. Writing window_length restarts the window.
// Reset (synchronous) empties the pipeline, clears sums and window position and
// loads window_length 2048 and char_offset 31. Store contents need no clearing.
module rolling_checksum_window_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rcw_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rcw_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                       accept;
   logic                       busy;
   logic                       clear_sums;
   logic [rcw_pkg::ADDR_W-1:0] ram_addr;
   logic [7:0]                 old_byte;
   rcw_pkg::meta_type          meta;
   rcw_pkg::cfg_type           cfg;

   // Input handshake: stall only when the sum stage cannot move on
   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign csr_ready = 1'b1;

   rcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ram_addr   (ram_addr),
      .meta       (meta),
      .cfg        (cfg),
      .clear_sums (clear_sums)
   );

   rcw_window_ram u_ram (
      .clock   (clock),
      .access  (accept),
      .addr    (ram_addr),
      .wr_data (req_data.data_byte),
      .rd_data (old_byte)
   );

   rcw_sum u_sum (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .meta       (meta),
      .cfg        (cfg),
      .clear_sums (clear_sums),
      .old_byte   (old_byte),
      .rsp_stall  (rsp_stall),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// File: src/rcw_checker.sv
// Port-level checker for the rolling checksum window unit, with its bind.
module rcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rcw_pkg::rsp_type rsp_data
);

   // A stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // No result right after reset
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An eviction only happens with a full window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted_valid |-> rsp_data.window_full)
      else $error("eviction without full window");

   // Evicted byte reads zero when nothing was pushed out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted_valid |-> rsp_data.evicted_byte == 8'd0)
      else $error("evicted byte set without eviction");

endmodule

bind rolling_checksum_window_unit rcw_checker u_rcw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
